// ===== hw/rtl/md5_pkg.sv =====
// Shared types, constants and round functions for the MD5 digest block.
package md5_pkg;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Front to block queue: word write and block push.
  typedef struct packed {
    logic        we;
    logic [3:0]  idx;
    logic [31:0] data;
    logic        push;
    logic        last;
  } md5_wr_req_t;

  // Block queue status.
  typedef struct packed {
    logic free;   // a slot is open for the front
    logic avail;  // a complete block waits for the core
    logic last;   // head block ends its message
  } md5_q_stat_t;

  // Core to block queue: word read and block pop.
  typedef struct packed {
    logic [3:0] idx;
    logic       pop;
  } md5_rd_req_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    return K_TABLE[i];
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index used by round i.
  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'({i[1:0], 2'b00} + i[3:0] + 4'd1);
      2'd2: g = 4'({i[2:0], 1'b0} + i[3:0] + 4'd5);
      default: g = 4'({i[0], 3'b000} - i[3:0]);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

// ===== hw/rtl/md5_front.sv =====
// Front end: takes bytes, packs words, tracks length and generates padding blocks.
module md5_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic                     in_op,
  input  logic [7:0]               in_byte,
  input  md5_pkg::md5_q_stat_t     q_stat,
  output md5_pkg::md5_wr_req_t     wr_req
);

  typedef enum logic [1:0] {
    F_BYTE = 2'b01,
    F_PAD  = 2'b10
  } front_state_t;

  front_state_t state_r, state_nxt;
  logic [60:0]  count_r, count_nxt;
  logic [31:0]  word_r, word_nxt;
  logic [5:0]   pfill_r, pfill_nxt;
  logic [3:0]   pidx_r, pidx_nxt;
  logic         second_r, second_nxt;

  logic         accept;
  logic         final_blk;
  logic [31:0]  mark_word;
  logic [31:0]  pad_word;

  assign in_tready = (state_r == F_BYTE) && q_stat.free;
  assign accept    = in_tvalid && in_tready;

  // final block of padding: the first if the marker leaves room for the length
  assign final_blk = second_r || (pfill_r[5:3] != 3'b111);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < pfill_r[1:0]) begin
        mark_word[8*j +: 8] = word_r[8*j +: 8];
      end else if (2'(j) == pfill_r[1:0]) begin
        mark_word[8*j +: 8] = md5_pkg::PAD_MARK;
      end else begin
        mark_word[8*j +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    if (!second_r && pidx_r == pfill_r[5:2]) begin
      pad_word = mark_word;
    end else if (final_blk && pidx_r == 4'd14) begin
      pad_word = {count_r[28:0], 3'b000};
    end else if (final_blk && pidx_r == 4'd15) begin
      pad_word = count_r[60:29];
    end else begin
      pad_word = 32'h0;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    word_nxt   = word_r;
    pfill_nxt  = pfill_r;
    pidx_nxt   = pidx_r;
    second_nxt = second_r;
    wr_req     = '0;
    unique case (state_r)
      F_BYTE: begin
        if (accept) begin
          if (in_op == md5_pkg::OP_END) begin
            pfill_nxt  = count_r[5:0];
            pidx_nxt   = count_r[5:2];
            second_nxt = 1'b0;
            state_nxt  = F_PAD;
          end else begin
            word_nxt[{count_r[1:0], 3'b000} +: 8] = in_byte;
            count_nxt = count_r + 61'd1;
            if (count_r[1:0] == 2'd3) begin
              wr_req.we   = 1'b1;
              wr_req.idx  = count_r[5:2];
              wr_req.data = word_nxt;
              wr_req.push = (count_r[5:2] == 4'd15);
            end
          end
        end
      end
      F_PAD: begin
        if (q_stat.free) begin
          wr_req.we   = 1'b1;
          wr_req.idx  = pidx_r;
          wr_req.data = pad_word;
          if (pidx_r == 4'd15) begin
            wr_req.push = 1'b1;
            wr_req.last = final_blk;
            pidx_nxt    = 4'd0;
            if (final_blk) begin
              count_nxt = '0;
              state_nxt = F_BYTE;
            end else begin
              second_nxt = 1'b1;
            end
          end else begin
            pidx_nxt = pidx_r + 4'd1;
          end
        end
      end
      default: state_nxt = F_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_BYTE;
      count_r  <= '0;
      second_r <= 1'b0;
      pidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      second_r <= second_nxt;
      pidx_r   <= pidx_nxt;
    end
    word_r  <= word_nxt;
    pfill_r <= pfill_nxt;
  end

endmodule

// ===== hw/rtl/md5_blkq.sv =====
// Two-slot block queue of sixteen message words each, between front and core.
module md5_blkq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  md5_pkg::md5_wr_req_t  wr_req,
  input  md5_pkg::md5_rd_req_t  rd_req,
  output md5_pkg::md5_q_stat_t  q_stat,
  output logic [31:0]           rdata
);

  logic [31:0] mem [32];
  logic [31:0] rdata_r;
  logic [1:0]  count_r;
  logic        wr_slot_r;
  logic        rd_slot_r;
  logic [1:0]  last_r;

  assign q_stat.free  = (count_r != 2'd2);
  assign q_stat.avail = (count_r != 2'd0);
  assign q_stat.last  = last_r[rd_slot_r];
  assign rdata        = rdata_r;

  always_ff @(posedge clk) begin
    if (wr_req.we) begin
      mem[{wr_slot_r, wr_req.idx}] <= wr_req.data;
    end
    rdata_r <= mem[{rd_slot_r, rd_req.idx}];
    if (wr_req.push) begin
      last_r[wr_slot_r] <= wr_req.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      wr_slot_r <= 1'b0;
      rd_slot_r <= 1'b0;
    end else begin
      if (wr_req.push) begin
        wr_slot_r <= ~wr_slot_r;
      end
      if (rd_req.pop) begin
        rd_slot_r <= ~rd_slot_r;
      end
      if (wr_req.push && !rd_req.pop) begin
        count_r <= count_r + 2'd1;
      end else if (!wr_req.push && rd_req.pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/md5_core.sv =====
// Back end: one MD5 round per cycle, chaining update and digest output register.
module md5_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  md5_pkg::md5_q_stat_t  q_stat,
  input  logic [31:0]           rdata,
  output md5_pkg::md5_rd_req_t  rd_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [127:0]          out_data
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_FIN  = 3'b100
  } core_state_t;

  core_state_t  state_r, state_nxt;
  logic [5:0]   i_r, i_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r, a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0]  ak_r, ak_nxt;
  logic [31:0]  ha_r, hb_r, hc_r, hd_r, ha_nxt, hb_nxt, hc_nxt, hd_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic [127:0] odata_r, odata_nxt;

  logic [5:0]   i_inc;
  logic [31:0]  f_val;
  logic [31:0]  t_sum;
  logic [31:0]  sa, sb, sc, sd;
  logic         out_free;

  assign i_inc     = i_r + 6'd1;
  assign out_free  = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  assign sa = ha_r + a_r;
  assign sb = hb_r + b_r;
  assign sc = hc_r + c_r;
  assign sd = hd_r + d_r;

  always_comb begin
    unique case (i_r[5:4])
      2'd0: f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1: f_val = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
  end

  // a + K is precomputed and registered; the word arrives from the queue read port
  assign t_sum = ak_r + f_val + rdata;

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    ak_nxt     = ak_r;
    ha_nxt     = ha_r;
    hb_nxt     = hb_r;
    hc_nxt     = hc_r;
    hd_nxt     = hd_r;
    odata_nxt  = odata_r;
    ovalid_nxt = ovalid_r && !out_ready;
    rd_req     = '0;
    unique case (state_r)
      C_IDLE: begin
        rd_req.idx = md5_pkg::word_sel(6'd0);
        if (q_stat.avail) begin
          a_nxt     = ha_r;
          b_nxt     = hb_r;
          c_nxt     = hc_r;
          d_nxt     = hd_r;
          ak_nxt    = ha_r + md5_pkg::round_k(6'd0);
          i_nxt     = 6'd0;
          state_nxt = C_RUN;
        end
      end
      C_RUN: begin
        rd_req.idx = md5_pkg::word_sel(i_inc);
        a_nxt  = d_r;
        d_nxt  = c_r;
        c_nxt  = b_r;
        b_nxt  = b_r + md5_pkg::rotl(t_sum, md5_pkg::rot_amt(i_r));
        ak_nxt = d_r + md5_pkg::round_k(i_inc);
        i_nxt  = i_inc;
        if (i_r == 6'd63) begin
          state_nxt = C_FIN;
        end
      end
      C_FIN: begin
        if (!q_stat.last) begin
          ha_nxt     = sa;
          hb_nxt     = sb;
          hc_nxt     = sc;
          hd_nxt     = sd;
          rd_req.pop = 1'b1;
          state_nxt  = C_IDLE;
        end else if (out_free) begin
          odata_nxt  = {sd, sc, sb, sa};
          ovalid_nxt = 1'b1;
          ha_nxt     = md5_pkg::IV_A;
          hb_nxt     = md5_pkg::IV_B;
          hc_nxt     = md5_pkg::IV_C;
          hd_nxt     = md5_pkg::IV_D;
          rd_req.pop = 1'b1;
          state_nxt  = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= C_IDLE;
      ovalid_r <= 1'b0;
      ha_r     <= md5_pkg::IV_A;
      hb_r     <= md5_pkg::IV_B;
      hc_r     <= md5_pkg::IV_C;
      hd_r     <= md5_pkg::IV_D;
      i_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      ha_r     <= ha_nxt;
      hb_r     <= hb_nxt;
      hc_r     <= hc_nxt;
      hd_r     <= hd_nxt;
      i_r      <= i_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    d_r     <= d_nxt;
    ak_r    <= ak_nxt;
    odata_r <= odata_nxt;
  end

endmodule

// ===== hw/rtl/md5_message_digest.sv =====
// MD5 digest engine top level: byte stream in, 128-bit digest out.
//
// Usage: input requests carry one byte on in_tdata with in_tuser = 0, or an
//   end-of-message marker with in_tuser = 1 (in_tdata ignored). One output request
//   follows each end marker: out_tdata holds digest words A..D, A in the low 32 bits,
//   each word the digest bytes in little-endian order. After the digest the
//   chaining state is back at the initial values.
// Throughput: bytes are taken one per cycle while a queue slot is open and no
//   end marker is being padded. The core runs one round per cycle; each 64-byte
//   block takes a start step, 64 rounds and a chaining add, and the
//   two-slot block queue lets the front fill one block while the core works on
//   the other.
// Padding: an end marker holds off input while its padding words are written
//   (one or two final blocks, longer while the queue is full), and the digest
//   is registered when the core finishes the last block and the output is free.
// Reset: synchronous active-low rst_n empties the queue, clears the byte count
//   and loads the initial chaining words.
// Stall: if out_tready is low the digest is held in the output register; the next
//   message streams in meanwhile and the core waits only when it must present a
//   further digest.
module md5_message_digest (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic [0:0]   in_tuser,   // [0] op (0 append byte, 1 end message)
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // [31:0] digest_a, [63:32] digest_b,
                                   // [95:64] digest_c, [127:96] digest_d
);

  md5_pkg::md5_wr_req_t wr_req;
  md5_pkg::md5_rd_req_t rd_req;
  md5_pkg::md5_q_stat_t q_stat;
  logic [31:0]          q_rdata;

  // byte packing, length count and padding
  md5_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser[0]),
    .in_byte   (in_tdata),
    .q_stat    (q_stat),
    .wr_req    (wr_req)
  );

  // double block buffer between front and core
  md5_blkq u_blkq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_req (wr_req),
    .rd_req (rd_req),
    .q_stat (q_stat),
    .rdata  (q_rdata)
  );

  // round engine and digest register
  md5_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .rdata     (q_rdata),
    .rd_req    (rd_req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ===== tb/sv/md5_message_digest_test.sv =====
// Self-checking stream testbench for the md5_message_digest block.
`timescale 1ns / 1ps

module md5_message_digest_test;

  // Stimulus stops once about this many input requests have been accepted.
  localparam int ITEM_TARGET = 1800;

  // Per-round additive constants, floor(abs(sin(i + 1)) * 2^32).
  localparam logic [31:0] ROUND_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts: four per round group, repeating within the group.
  localparam int ROT_BY [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;             // [7:0] data_byte
  logic [0:0]   in_tuser = md5_pkg::OP_DATA;  // [0] op
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;           // [31:0] a, [63:32] b, [95:64] c, [127:96] d

  md5_message_digest dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shared state between stimulus, sink and checker
  // ---------------------------------------------------------------------------
  logic [127:0] digest_queue [$];   // expected digests, {d, c, b, a}
  int           mismatch_count = 0;
  int           items_sent = 0;
  bit           no_idle = 1'b0;     // both sides run flat out while set
  int           hold_off_req = 0;   // cycles the sink is to hold out_tready low

  // Predicted block state: chaining words, partial block and byte count.
  logic [31:0]  chain_state [4];
  logic [511:0] block_bytes;        // byte k sits at bits [8k +: 8]
  logic [60:0]  byte_count;

  // ---------------------------------------------------------------------------
  // Digest predictor
  // ---------------------------------------------------------------------------
  function automatic void load_chain_iv();
    chain_state[0] = 32'h67452301;
    chain_state[1] = 32'hefcdab89;
    chain_state[2] = 32'h98badcfe;
    chain_state[3] = 32'h10325476;
  endfunction

  // One 64-round compression of a 64-byte block into the chaining words.
  function automatic void md5_compress(input logic [511:0] blk);
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int          g;
    int          s;
    for (int i = 0; i < 16; i++)
      w[i] = blk[32*i +: 32];     // bytes are little-endian within each word
    a = chain_state[0];
    b = chain_state[1];
    c = chain_state[2];
    d = chain_state[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      s = ROT_BY[(i / 16) * 4 + i % 4];
      t = a + f + w[g] + ROUND_ADD[i];
      t = (t << s) | (t >> (32 - s));
      a = d;
      d = c;
      c = b;
      b = b + t;
    end
    chain_state[0] += a;
    chain_state[1] += b;
    chain_state[2] += c;
    chain_state[3] += d;
  endfunction

  // Absorbs one accepted request. Returns 1 with the digest on an end marker.
  function automatic bit md5_absorb(input logic op, input logic [7:0] value,
                                    output logic [127:0] digest);
    int           fill;
    logic [511:0] pad;
    fill = int'(byte_count[5:0]);
    digest = '0;
    if (op == md5_pkg::OP_DATA) begin
      block_bytes[8*fill +: 8] = value;
      byte_count = byte_count + 61'd1;
      if (fill == 63)
        md5_compress(block_bytes);
      return 1'b0;
    end
    // End of message: 0x80 marker, zero fill, then the 64-bit bit length.
    // The data byte of the end request plays no part.
    pad = '0;
    for (int k = 0; k < fill; k++)
      pad[8*k +: 8] = block_bytes[8*k +: 8];
    pad[8*fill +: 8] = 8'h80;
    if (fill >= 56) begin
      // no room for the length in this block: it goes in one more
      md5_compress(pad);
      pad = '0;
    end
    // Bit length = count * 8 mod 2^64; the high word is count >> 29. The
    // count wrap at 2^61 bytes lies far beyond any simulated message.
    pad[448 +: 64] = {byte_count, 3'b000};
    md5_compress(pad);
    digest = {chain_state[3], chain_state[2], chain_state[1], chain_state[0]};
    load_chain_iv();
    byte_count = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: random gap, then hold the request until accepted
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic op, input logic [7:0] value);
    int           gap;
    int           r;
    logic [127:0] digest;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60)
      gap = 0;
    else if (r < 93)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (md5_absorb(op, value, digest))
      digest_queue.push_back(digest);
    items_sent++;
  endtask

  // Random bytes followed by an end marker carrying a random, ignored byte.
  task automatic send_message(input int len);
    for (int k = 0; k < len; k++)
      send_request(md5_pkg::OP_DATA, 8'($urandom_range(0, 255)));
    send_request(md5_pkg::OP_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic report_failure(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: out_tready pattern, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int len;
    forever begin
      @(posedge clk);
      if (hold_off_req > 0) begin
        len = hold_off_req;
        hold_off_req = 0;
        out_tready <= 1'b0;
        repeat (len) @(posedge clk);
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                           : $urandom_range(20, 80);
        repeat (len) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each digest against the oldest expectation, word by word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : digest_check
    logic [127:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_queue.size() == 0) begin
        report_failure($sformatf("digest %h with none expected", out_tdata));
      end else begin
        want = digest_queue.pop_front();
        for (int w = 0; w < 4; w++)
          if (out_tdata[32*w +: 32] !== want[32*w +: 32])
            report_failure($sformatf("digest_%c: got %h, want %h", 8'd97 + w,
                                     out_tdata[32*w +: 32], want[32*w +: 32]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty messages: end marker right after reset and right after another end,
  // with the ignored data byte at both extremes.
  task automatic test_empty_message();
    send_request(md5_pkg::OP_END, 8'h00);
    send_request(md5_pkg::OP_END, 8'hff);
  endtask

  // Short known strings, zero bytes and byte extremes inside the message.
  task automatic test_short_messages();
    send_request(md5_pkg::OP_DATA, 8'h61);
    send_request(md5_pkg::OP_DATA, 8'h62);
    send_request(md5_pkg::OP_DATA, 8'h63);
    send_request(md5_pkg::OP_END, 8'ha5);
    send_request(md5_pkg::OP_DATA, 8'h00);
    send_request(md5_pkg::OP_DATA, 8'hff);
    send_request(md5_pkg::OP_DATA, 8'h00);
    send_request(md5_pkg::OP_DATA, 8'h00);
    send_request(md5_pkg::OP_DATA, 8'hff);
    send_request(md5_pkg::OP_DATA, 8'h80);
    send_request(md5_pkg::OP_DATA, 8'h7f);
    send_request(md5_pkg::OP_DATA, 8'h55);
    send_request(md5_pkg::OP_DATA, 8'haa);
    send_request(md5_pkg::OP_END, 8'h5a);
    send_request(md5_pkg::OP_DATA, 8'h00);
    send_request(md5_pkg::OP_END, 8'h01);
  endtask

  // Lengths around the 56-byte point where padding spills into a second
  // block, and around the full-block boundary. Runs with no idling at all.
  task automatic test_pad_boundaries();
    no_idle = 1'b1;
    send_message(55);
    send_message(56);
    send_message(57);
    send_message(63);
    send_message(64);
    send_message(65);
    no_idle = 1'b0;
  endtask

  // Sink holds off long while several messages stream in back to back, so
  // the output register and the block queue fill and in_tready drops.
  task automatic test_output_backpressure();
    hold_off_req = 2000;
    no_idle = 1'b1;
    for (int m = 0; m < 4; m++)
      send_message($urandom_range(70, 130));
    no_idle = 1'b0;
  endtask

  // Random messages, weighted toward short ones and block boundaries.
  task automatic test_random_messages();
    int r;
    int len;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        len = $urandom_range(0, 16);
      else if (r < 70)
        len = 64 * $urandom_range(0, 1) + $urandom_range(54, 66);
      else if (r < 92)
        len = $urandom_range(17, 130);
      else
        len = $urandom_range(131, 300);
      send_message(len);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    load_chain_iv();
    block_bytes = '0;
    byte_count  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_message();
    test_short_messages();
    test_pad_boundaries();
    test_output_backpressure();
    test_random_messages();
    in_tvalid <= 1'b0;

    // drain outstanding digests, then give the core time to show a stray one
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #(5_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
